/* rtl/core/quintic_trajectory_point_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quintic trajectory point block
// Shared shorthand for concurrent checks clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef QUINTIC_TRAJECTORY_POINT_MACROS_SVH
`define QUINTIC_TRAJECTORY_POINT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define QTP_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("qtp: invariant violated");

// A condition that must hold whenever its antecedent does.
`define QTP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qtp: implication violated");

`endif

/* rtl/core/qtp_pkg.sv */
// ----------------------------------------------------------------------------
// qtp_pkg
// Shared constants, register indexes and pipeline side-band type.
// ----------------------------------------------------------------------------
package qtp_pkg;

    // Default widths of values and times.
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int TIME_WIDTH_DEF  = 24;

    // Fractional bits of the Q16.16 value format.
    localparam int FRAC_BITS = 16;

    // Width of one multiplier slice and latency of the wide multiplier.
    localparam int MUL_CHUNK = 24;
    localparam int MUL_LAT   = 3;

    // Depth of the queue between front and back.
    localparam int FIFO_DEPTH = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_WIDTH = 2;
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_START    = 2'd0,
        REG_END      = 2'd1,
        REG_DURATION = 2'd2
    } t_reg_idx;

    // Side-band flags that travel alongside an item through the back end.
    typedef struct packed {
        logic valid;
        logic ncfg;
        logic acc_flip;
    } t_side;

endpackage

/* rtl/core/qtp_fifo.sv */
// ----------------------------------------------------------------------------
// qtp_fifo
// Short first-in first-out queue decoupling the front from the back end.
// ----------------------------------------------------------------------------
module qtp_fifo import qtp_pkg::*; #(
    parameter int W     = 25,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [W-1:0]               i_data,
    input  logic                       i_pop,
    output logic [W-1:0]               o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_cnt;

    // Pointer wrap.
    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_count = r_cnt;

endmodule

/* rtl/core/qtp_front.sv */
// ----------------------------------------------------------------------------
// qtp_front
// Holds the configuration, derives the move constants and accepts items.
// ----------------------------------------------------------------------------
module qtp_front import qtp_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]           i_cfg_idx,
    input  logic [((VALUE_WIDTH > TIME_WIDTH) ? VALUE_WIDTH : TIME_WIDTH)-1:0] i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [TIME_WIDTH-1:0]              i_sample_time,
    input  logic                               i_fifo_full,
    output logic                               o_push,
    output logic [TIME_WIDTH:0]                o_push_data,
    output logic [VALUE_WIDTH-1:0]             o_start,
    output logic [VALUE_WIDTH:0]               o_dmag,
    output logic                               o_dneg,
    output logic [TIME_WIDTH-1:0]              o_dur,
    output logic [2*TIME_WIDTH-1:0]            o_dur_sq,
    output logic [5*TIME_WIDTH-1:0]            o_den
);
    localparam int VW    = VALUE_WIDTH;
    localparam int TW    = TIME_WIDTH;
    localparam int PW    = 5 * TW;
    localparam int BIT_W = $clog2(TW);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_MUL  = 3'b100
    } t_seq_state;

    t_seq_state       r_state;
    logic [VW-1:0]    r_start, r_end;
    logic [TW-1:0]    r_dur;
    logic [BIT_W-1:0] r_bit;
    logic [1:0]       r_round;
    logic [PW-1:0]    r_acc, r_mc, acc_step;
    logic [VW:0]      r_dmag, diff;
    logic             r_dneg;
    logic [2*TW-1:0]  r_dur_sq;
    logic [PW-1:0]    r_den;
    logic             last_bit;

    // One shift-add step of the power-of-duration multiply.
    assign acc_step = r_acc + (r_dur[r_bit] ? r_mc : '0);
    assign last_bit = (r_bit == BIT_W'(TW - 1));
    assign diff     = {r_end[VW-1], r_end} - {r_start[VW-1], r_start};

    // Configuration registers and the sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
            r_dur   <= '0;
            r_state <= S_IDLE;
            r_bit   <= '0;
            r_round <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_START:    r_start <= i_cfg_data[VW-1:0];
                REG_END:      r_end   <= i_cfg_data[VW-1:0];
                REG_DURATION: r_dur   <= i_cfg_data[TW-1:0];
                default: ;
            endcase
            r_state <= S_LOAD;
        end else begin
            unique case (r_state)
                S_IDLE: ;
                S_LOAD: begin
                    r_bit   <= '0;
                    r_round <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (last_bit) begin
                        r_bit   <= '0;
                        r_round <= r_round + 1'b1;
                        if (r_round == 2'd3) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_bit <= r_bit + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Derived constants: difference, duration squared and duration to the fifth.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_acc  <= '0;
            r_mc   <= PW'(r_dur);
            r_dneg <= diff[VW];
            r_dmag <= diff[VW] ? (~diff + 1'b1) : diff;
        end else if (r_state == S_MUL) begin
            if (last_bit) begin
                r_acc <= '0;
                r_mc  <= acc_step;
                if (r_round == 2'd0) begin
                    r_dur_sq <= acc_step[2*TW-1:0];
                end
                if (r_round == 2'd3) begin
                    r_den <= acc_step;
                end
            end else begin
                r_acc <= acc_step;
                r_mc  <= r_mc << 1;
            end
        end
    end

    // Item acceptance; a zero duration marks the item as unconfigured.
    assign o_ready     = (r_state == S_IDLE) && !i_fifo_full;
    assign o_push      = i_valid && o_ready;
    assign o_push_data = {(r_dur == '0), i_sample_time};

    assign o_start  = r_start;
    assign o_dmag   = r_dmag;
    assign o_dneg   = r_dneg;
    assign o_dur    = r_dur;
    assign o_dur_sq = r_dur_sq;
    assign o_den    = r_den;

endmodule

/* rtl/core/qtp_wmul.sv */
// ----------------------------------------------------------------------------
// qtp_wmul
// Pipelined wide multiplier built from slice products, row sums and a total.
// ----------------------------------------------------------------------------
module qtp_wmul import qtp_pkg::*; #(
    parameter int AW = 48,
    parameter int BW = 24
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);
    localparam int CW = MUL_CHUNK;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int RW = (NB + 1) * CW;
    localparam int SW = (NA + NB) * CW;
    localparam int PW = AW + BW;

    logic [NA*CW-1:0] a_pad;
    logic [NB*CW-1:0] b_pad;
    logic [2*CW-1:0]  r_pp [NA*NB];
    logic [RW-1:0]    r_row [NA];
    logic [RW-1:0]    n_row [NA];
    logic [PW-1:0]    r_p;
    logic [SW-1:0]    n_sum;

    assign a_pad = (NA*CW)'(i_a);
    assign b_pad = (NB*CW)'(i_b);

    // Row sums and the final total.
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (RW'(r_pp[i*NB+j]) << (j * CW));
            end
        end
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (SW'(r_row[i]) << (i * CW));
        end
    end

    // Three register stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= (2*CW)'(a_pad[i*CW +: CW]) * (2*CW)'(b_pad[j*CW +: CW]);
                end
                r_row[i] <= n_row[i];
            end
            r_p <= n_sum[PW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

/* rtl/core/qtp_div.sv */
// ----------------------------------------------------------------------------
// qtp_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module qtp_div #(
    parameter int NW = 160,
    parameter int DW = 120,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_q,
    output logic          o_rem_nz,
    output logic          o_ovf
);
    localparam int W = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [W-1:0]  r_rem [QW];
    logic [W-1:0]  n_rem [QW];
    logic [QW-1:0] r_q   [QW];
    logic [QW-1:0] n_q   [QW];
    logic          r_ovf [QW];
    logic          n_ovf [QW];

    // Each stage tries to take the shifted divisor off the partial remainder.
    always_comb begin
        logic [W-1:0]  rin;
        logic [W-1:0]  sh;
        logic [QW-1:0] qin;
        logic          oin;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                rin = W'(i_num);
                qin = '0;
                oin = W'(i_num) >= (W'(i_den) << QW);
            end else begin
                rin = r_rem[k-1];
                qin = r_q[k-1];
                oin = r_ovf[k-1];
            end
            sh = W'(i_den) << (QW - 1 - k);
            if (rin >= sh) begin
                n_rem[k] = rin - sh;
                n_q[k]   = qin | (QW'(1) << (QW - 1 - k));
            end else begin
                n_rem[k] = rin;
                n_q[k]   = qin;
            end
            n_ovf[k] = oin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_ovf[k] <= n_ovf[k];
            end
        end
    end

    assign o_q      = r_q[QW-1];
    assign o_rem_nz = |r_rem[QW-1];
    assign o_ovf    = r_ovf[QW-1];

endmodule

/* rtl/core/qtp_back.sv */
// ----------------------------------------------------------------------------
// qtp_back
// Evaluation pipeline: powers of time, wide products, floor division, clipping.
// ----------------------------------------------------------------------------
module qtp_back import qtp_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [TIME_WIDTH:0]        i_item,
    input  logic                       i_empty,
    output logic                       o_pop,
    input  logic [VALUE_WIDTH-1:0]     i_start,
    input  logic [VALUE_WIDTH:0]       i_dmag,
    input  logic                       i_dneg,
    input  logic [TIME_WIDTH-1:0]      i_dur,
    input  logic [2*TIME_WIDTH-1:0]    i_dur_sq,
    input  logic [5*TIME_WIDTH-1:0]    i_den,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [VALUE_WIDTH-1:0]     o_position,
    output logic [VALUE_WIDTH-1:0]     o_velocity,
    output logic [VALUE_WIDTH-1:0]     o_acceleration,
    output logic                       o_not_configured,
    output logic                       o_saturated
);
    localparam int VW  = VALUE_WIDTH;
    localparam int TW  = TIME_WIDTH;
    localparam int QBW = 2 * TW + 4;
    localparam int PNW = 5 * TW + VW + 5;
    localparam int V2W = 4 * TW + VW + 1;
    localparam int VNW = V2W + 5 + FRAC_BITS;
    localparam int A2W = 3 * TW + VW + 2;
    localparam int ANW = A2W + 6 + 2 * FRAC_BITS;
    localparam int SIDE_LEN = 2 * MUL_LAT + 1 + VW;

    logic en;

    // Stage A: squares, products with the duration and distances to it.
    t_side            r_a_side;
    logic [TW-1:0]    r_a_s, r_a_m1;
    logic [TW:0]      r_a_m2;
    logic [2*TW-1:0]  r_a_s2, r_a_st;
    logic [TW-1:0]    s, m1;
    logic [TW:0]      s_twice, dur_ext, m2;
    logic             n1, n2;

    // Stage B: cube, the position factor and the velocity and acceleration factors.
    t_side            r_b_side;
    logic [3*TW-1:0]  r_b_s3;
    logic [QBW-1:0]   r_b_q, q_s2, q_t2, q_st;
    logic [2*TW-1:0]  r_b_s2, r_b_m1sq, r_b_sm1;
    logic [TW:0]      r_b_m2;

    // Multiplier chain outputs.
    logic [5*TW+3:0]  p1;
    logic [4*TW-1:0]  v1;
    logic [3*TW:0]    a1;
    logic [PNW-1:0]   p2;
    logic [V2W-1:0]   v2;
    logic [A2W-1:0]   a2;

    // Stage C: scaled numerators.
    logic [PNW-1:0]   r_c_pnum;
    logic [VNW-1:0]   r_c_vnum, v_ext;
    logic [ANW-1:0]   r_c_anum, a_ext;

    // Divider outputs.
    logic [VW-1:0]    pq, vq, aq;
    logic             p_rnz, v_rnz, a_rnz, p_ovf, v_ovf, a_ovf;

    // Side-band delay line and output register.
    t_side            r_side [SIDE_LEN];
    t_side            side_end;
    logic             r_out_valid, r_ncfg, r_sat;
    logic [VW-1:0]    r_pos, r_vel, r_acc;
    logic [VW:0]      p_clip, v_clip, a_clip;
    logic             acc_neg;

    // Signed floor quotient from magnitude, remainder flag and sign.
    function automatic logic signed [VW+2:0] signed_quot(
        input logic [VW-1:0] q, input logic rnz, input logic neg);
        logic [VW+2:0] mag;
        mag = (VW+3)'(q) + (VW+3)'(neg && rnz);
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    // Saturate to the value range; the top bit of the result flags clipping.
    function automatic logic [VW:0] clip(
        input logic signed [VW+2:0] x, input logic ovf, input logic neg);
        logic [VW-1:0]         vmax, vmin;
        logic signed [VW+2:0]  maxv, minv;
        logic [VW:0]           r;
        vmax = {1'b0, {(VW-1){1'b1}}};
        vmin = {1'b1, {(VW-1){1'b0}}};
        maxv = $signed({3'b000, vmax});
        minv = $signed({3'b111, vmin});
        if (ovf) begin
            r = {1'b1, (neg ? vmin : vmax)};
        end else if (x > maxv) begin
            r = {1'b1, vmax};
        end else if (x < minv) begin
            r = {1'b1, vmin};
        end else begin
            r = {1'b0, x[VW-1:0]};
        end
        return r;
    endfunction

    // The whole pipeline moves unless a finished result waits to be taken.
    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_empty;

    // Stage A combinational terms.
    assign s       = i_item[TW-1:0];
    assign n1      = i_dur < s;
    assign m1      = n1 ? (s - i_dur) : (i_dur - s);
    assign s_twice = {s, 1'b0};
    assign dur_ext = {1'b0, i_dur};
    assign n2      = dur_ext < s_twice;
    assign m2      = n2 ? (s_twice - dur_ext) : (dur_ext - s_twice);

    // Stage B: 6 s^2 + 10 T^2 - 15 s T, positive unless s and T are both zero.
    assign q_s2 = QBW'(r_a_s2);
    assign q_t2 = QBW'(i_dur_sq);
    assign q_st = QBW'(r_a_st);

    // Control flags of stages A and B.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
            r_b_side <= '0;
        end else if (en) begin
            r_a_side <= '{valid: o_pop, ncfg: i_item[TW], acc_flip: n1 ^ n2};
            r_b_side <= r_a_side;
        end
    end

    // Payload of stages A, B and C; the cube is formed from two half products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_s    <= s;
            r_a_s2   <= (2*TW)'(s) * (2*TW)'(s);
            r_a_st   <= (2*TW)'(s) * (2*TW)'(i_dur);
            r_a_m1   <= m1;
            r_a_m2   <= m2;
            r_b_s3   <= (((3*TW)'(r_a_s2[2*TW-1:TW]) * (3*TW)'(r_a_s)) << TW)
                        + (3*TW)'(r_a_s2[TW-1:0]) * (3*TW)'(r_a_s);
            r_b_q    <= (q_s2 << 2) + (q_s2 << 1) + (q_t2 << 3) + (q_t2 << 1)
                        - ((q_st << 4) - q_st);
            r_b_s2   <= r_a_s2;
            r_b_m1sq <= (2*TW)'(r_a_m1) * (2*TW)'(r_a_m1);
            r_b_sm1  <= (2*TW)'(r_a_s) * (2*TW)'(r_a_m1);
            r_b_m2   <= r_a_m2;
            r_c_pnum <= p2;
            r_c_vnum <= ((v_ext << 5) - (v_ext << 1)) << FRAC_BITS;
            r_c_anum <= ((a_ext << 6) - (a_ext << 2)) << (2 * FRAC_BITS);
        end
    end

    assign v_ext = VNW'(v2);
    assign a_ext = ANW'(a2);

    // Position: s^3 * q * |D|.
    qtp_wmul #(.AW(3*TW), .BW(QBW)) u_pos_mul1 (
        .i_clk(i_clk), .i_en(en), .i_a(r_b_s3), .i_b(r_b_q), .o_p(p1));
    qtp_wmul #(.AW(5*TW+4), .BW(VW+1)) u_pos_mul2 (
        .i_clk(i_clk), .i_en(en), .i_a(p1), .i_b(i_dmag), .o_p(p2));

    // Velocity: s^2 * (T-s)^2 * |D|.
    qtp_wmul #(.AW(2*TW), .BW(2*TW)) u_vel_mul1 (
        .i_clk(i_clk), .i_en(en), .i_a(r_b_s2), .i_b(r_b_m1sq), .o_p(v1));
    qtp_wmul #(.AW(4*TW), .BW(VW+1)) u_vel_mul2 (
        .i_clk(i_clk), .i_en(en), .i_a(v1), .i_b(i_dmag), .o_p(v2));

    // Acceleration: s * |T-s| * |T-2s| * |D|.
    qtp_wmul #(.AW(2*TW), .BW(TW+1)) u_acc_mul1 (
        .i_clk(i_clk), .i_en(en), .i_a(r_b_sm1), .i_b(r_b_m2), .o_p(a1));
    qtp_wmul #(.AW(3*TW+1), .BW(VW+1)) u_acc_mul2 (
        .i_clk(i_clk), .i_en(en), .i_a(a1), .i_b(i_dmag), .o_p(a2));

    // Floor division by T^5 for each output.
    qtp_div #(.NW(PNW), .DW(5*TW), .QW(VW)) u_pos_div (
        .i_clk(i_clk), .i_en(en), .i_num(r_c_pnum), .i_den(i_den),
        .o_q(pq), .o_rem_nz(p_rnz), .o_ovf(p_ovf));
    qtp_div #(.NW(VNW), .DW(5*TW), .QW(VW)) u_vel_div (
        .i_clk(i_clk), .i_en(en), .i_num(r_c_vnum), .i_den(i_den),
        .o_q(vq), .o_rem_nz(v_rnz), .o_ovf(v_ovf));
    qtp_div #(.NW(ANW), .DW(5*TW), .QW(VW)) u_acc_div (
        .i_clk(i_clk), .i_en(en), .i_num(r_c_anum), .i_den(i_den),
        .o_q(aq), .o_rem_nz(a_rnz), .o_ovf(a_ovf));

    // Side-band flags follow their item through multipliers and dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SIDE_LEN; k++) begin
                r_side[k] <= '0;
            end
        end else if (en) begin
            r_side[0] <= r_b_side;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign side_end = r_side[SIDE_LEN-1];
    assign acc_neg  = i_dneg ^ side_end.acc_flip;

    // Sign, offset by the start value and clip.
    always_comb begin
        p_clip = clip(signed_quot(pq, p_rnz, i_dneg) + $signed({{3{i_start[VW-1]}}, i_start}),
                      p_ovf, i_dneg);
        v_clip = clip(signed_quot(vq, v_rnz, i_dneg), v_ovf, i_dneg);
        a_clip = clip(signed_quot(aq, a_rnz, acc_neg), a_ovf, acc_neg);
    end

    // Output register; an unconfigured item gives zeros.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= side_end.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ncfg <= side_end.ncfg;
            if (side_end.ncfg) begin
                r_pos <= '0;
                r_vel <= '0;
                r_acc <= '0;
                r_sat <= 1'b0;
            end else begin
                r_pos <= p_clip[VW-1:0];
                r_vel <= v_clip[VW-1:0];
                r_acc <= a_clip[VW-1:0];
                r_sat <= p_clip[VW] | v_clip[VW] | a_clip[VW];
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_position       = r_pos;
    assign o_velocity       = r_vel;
    assign o_acceleration   = r_acc;
    assign o_not_configured = r_ncfg;
    assign o_saturated      = r_sat;

endmodule

/* rtl/core/quintic_trajectory_point.sv */
// ----------------------------------------------------------------------------
// quintic_trajectory_point
// Position, velocity and acceleration of a rest-to-rest quintic move.
// ----------------------------------------------------------------------------
//  Channel     Direction  Payload
//  s_axis      in         tdata: sample_time
//  m_axis      out        tdata: position, velocity, acceleration;
//                         tuser: not_configured, saturated
//  cfg         in         start_value, end_value, duration by index
//
//  One item per cycle while the output is taken and the sequencer is idle;
//  items pass stages A and B, chains of two three-stage multipliers,
//  stage C, the bit-per-stage dividers and the output register.
//  After any configuration write, input is held off while duration^5 is formed.
//  Reset is synchronous and active low. A stalled output freezes the back
//  end; a four-entry queue lets the input side keep taking items meanwhile.
// ----------------------------------------------------------------------------
`include "quintic_trajectory_point_macros.svh"

module quintic_trajectory_point import qtp_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]              i_cfg_idx,
    input  logic [((VALUE_WIDTH > TIME_WIDTH) ? VALUE_WIDTH : TIME_WIDTH)-1:0] i_cfg_data,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // sample_time
    input  logic [((TIME_WIDTH + 7) / 8) * 8-1:0] i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // position, velocity, acceleration
    output logic [((3 * VALUE_WIDTH + 7) / 8) * 8-1:0] o_m_axis_tdata,
    // not_configured, saturated
    output logic [1:0]                            o_m_axis_tuser
);
    localparam int VW    = VALUE_WIDTH;
    localparam int TW    = TIME_WIDTH;
    localparam int OTW   = ((3 * VW + 7) / 8) * 8;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic                 push, pop, fifo_full, fifo_empty;
    logic [TW:0]          push_data, pop_data;
    logic [CNT_W-1:0]     fifo_count;
    logic [VW-1:0]        start, pos, vel, acc;
    logic [VW:0]          dmag;
    logic                 dneg, ncfg, sat;
    logic [TW-1:0]        dur;
    logic [2*TW-1:0]      dur_sq;
    logic [5*TW-1:0]      den;

    // Front: configuration, derived constants and item acceptance.
    qtp_front #(.VALUE_WIDTH(VW), .TIME_WIDTH(TW)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_sample_time (i_s_axis_tdata[TW-1:0]),
        .i_fifo_full   (fifo_full),
        .o_push        (push),
        .o_push_data   (push_data),
        .o_start       (start),
        .o_dmag        (dmag),
        .o_dneg        (dneg),
        .o_dur         (dur),
        .o_dur_sq      (dur_sq),
        .o_den         (den)
    );

    // Queue between front and back.
    qtp_fifo #(.W(TW + 1), .DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_empty (fifo_empty),
        .o_full  (fifo_full),
        .o_count (fifo_count)
    );

    // Back: evaluation pipeline and output register.
    qtp_back #(.VALUE_WIDTH(VW), .TIME_WIDTH(TW)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (pop_data),
        .i_empty          (fifo_empty),
        .o_pop            (pop),
        .i_start          (start),
        .i_dmag           (dmag),
        .i_dneg           (dneg),
        .i_dur            (dur),
        .i_dur_sq         (dur_sq),
        .i_den            (den),
        .o_valid          (o_m_axis_tvalid),
        .i_ready          (i_m_axis_tready),
        .o_position       (pos),
        .o_velocity       (vel),
        .o_acceleration   (acc),
        .o_not_configured (ncfg),
        .o_saturated      (sat)
    );

    assign o_m_axis_tdata = OTW'({acc, vel, pos});
    assign o_m_axis_tuser = {sat, ncfg};

    // Checks on queue bookkeeping and the unconfigured result.
    `QTP_ASSERT_ALWAYS(a_fifo_bound, fifo_count <= CNT_W'(FIFO_DEPTH))
    `QTP_ASSERT_IMPLY(a_push_room, push, !fifo_full)
    `QTP_ASSERT_IMPLY(a_pop_data, pop, !fifo_empty)
    `QTP_ASSERT_IMPLY(a_ncfg_zero, o_m_axis_tvalid && o_m_axis_tuser[0], (o_m_axis_tdata == '0) && !o_m_axis_tuser[1])

endmodule
